// ----- rtl/ttl_pkg.sv -----
// Package with the types, constants and codes shared by the tag track locator.
`default_nettype none
package ttl_pkg;

  localparam int TRACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TRACK_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int FRAC_BITS   = 8;

  localparam int D1S_W  = 16 + FRAC_BITS;          // dist1 in fixed point
  localparam int MAG_W  = 33 + FRAC_BITS;          // |num| << FRAC_BITS
  localparam int RAD_W  = 2 * D1S_W;               // radicand of the root
  localparam int DIFF_W = 5 + FRAC_BITS;           // |dx|, |dy| below 32 units
  localparam int DS_W   = 2 * DIFF_W + 1;          // squared distance
  localparam int YV_W   = MAG_W + 2;               // signed y for the scan

  localparam logic [15:0] HEADER_OK = 16'hD66D;
  localparam logic [7:0]  TYPE_OK   = 8'h02;
  localparam logic [DS_W-1:0] BEST_INIT = DS_W'(1000) << (2 * FRAC_BITS);
  localparam logic [DIFF_W:0] NEAR_SPAN = (DIFF_W+1)'(32) << FRAC_BITS;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_HDR  = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_BAD_TAG  = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;

  localparam logic [2:0] REG_LENGTH  = 3'd0;
  localparam logic [2:0] REG_WIDTH   = 3'd1;
  localparam logic [2:0] REG_RADIUS  = 3'd2;
  localparam logic [2:0] REG_ARC     = 3'd3;
  localparam logic [2:0] REG_POINTS  = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  point_index;
    logic [9:0]  point_x;
    logic [9:0]  point_y;
    logic [15:0] header_word;
    logic [7:0]  frame_type;
    logic [7:0]  frame_tag;
    logic        expected_tag;
    logic [15:0] dist0;
    logic [15:0] dist1;
    logic [15:0] dist2;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        tag_out;
    logic [2:0]  segment;
    logic [13:0] offset_q4;
    logic [9:0]  track_distance;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_NUM, S_DIV, S_YFIX, S_SQ, S_RAD, S_SQRT, S_SCAN, S_SEG
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/tag_track_locator_unit.sv -----
// Top level of the tag track locator: frame check, circle intersection, point search.
`default_nettype none
// A beat is accepted when start is high and busy is low. A load beat writes one track
// point into the point memory in that cycle and gives no result. A frame beat with a
// bad header, type, tag or a zero distance gives its error result in the next cycle and
// leaves busy low. A good frame beat runs a sequence: squares, the numerator, a
// restoring divider (one quotient bit a cycle), rounding, forming the radicand, the
// digit-by-digit square root (skipped when there is no intersection or the track height
// is zero), then the nearest-point scan over min(track_points, 1024) entries at one
// memory read a cycle plus the pipeline drain, and a walk over the segment boundaries.
// The result is shown for one cycle with done high; the receiver cannot stall it, so
// it must take it then. Configuration writes take effect at once, so they belong in
// cycles where busy is low and no frame is in flight.
module tag_track_locator_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire ttl_pkg::cmd_t    command,
  output logic                  done,
  output ttl_pkg::result_t      result,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [13:0]      cfg_data
);
  import ttl_pkg::*;

  // Configuration registers.
  logic [9:0]  track_length;
  logic [9:0]  track_width;
  logic [8:0]  corner_radius;
  logic [13:0] quarter_arc_q4;
  logic [10:0] track_points;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_length   <= 10'd122;
      track_width    <= 10'd80;
      corner_radius  <= 9'd85;
      quarter_arc_q4 <= 14'd2136;
      track_points   <= 11'd938;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LENGTH: track_length   <= cfg_data[9:0];
        REG_WIDTH:  track_width    <= cfg_data[9:0];
        REG_RADIUS: corner_radius  <= cfg_data[8:0];
        REG_ARC:    quarter_arc_q4 <= cfg_data;
        REG_POINTS: track_points   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // Frame check on the incoming beat.
  logic [2:0] chk_status;
  always_comb begin
    if (command.header_word != HEADER_OK) chk_status = ST_BAD_HDR;
    else if (command.frame_type != TYPE_OK) chk_status = ST_BAD_TYPE;
    else if (command.frame_tag != {7'd0, command.expected_tag}) chk_status = ST_BAD_TAG;
    else if (command.dist0 == 16'd0 || command.dist1 == 16'd0 || command.dist2 == 16'd0)
      chk_status = ST_ZERO;
    else chk_status = ST_OK;
  end

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Point memory: x in the upper half of each word, y in the lower.
  logic [19:0] point_mem [TRACK_DEPTH];
  logic [19:0] rd_data;
  logic [CNT_W-1:0] issue_cnt;

  always_ff @(posedge clk) begin
    if (accept && command.cmd == CMD_LOAD)
      point_mem[command.point_index[ADDR_W-1:0]] <= {command.point_x, command.point_y};
    rd_data <= point_mem[issue_cnt[ADDR_W-1:0]];
  end

  // Frame datapath registers.
  logic [15:0]        d1, d2;
  logic               etag;
  logic [10:0]        h;
  logic [31:0]        d1sq, d2sq;
  logic [21:0]        hsq;
  logic               y_neg;
  logic [MAG_W-1:0]   dvd;
  logic [11:0]        drem;
  logic [11:0]        den;
  logic [5:0]         step;
  logic [MAG_W-1:0]   ya;
  logic [D1S_W-1:0]   d1s;
  logic [D1S_W-1:0]   xq;
  logic [RAD_W-1:0]   p_d, p_y, rad;
  logic [D1S_W-1:0]   root;
  logic [D1S_W+2:0]   srem;
  logic [CNT_W-1:0]   scan_cnt;

  assign d1s = {d1, {FRAC_BITS{1'b0}}};

  // Divider step.
  logic [12:0] div_sh;
  logic        div_ge;
  assign div_sh = {drem, dvd[MAG_W-1]};
  assign div_ge = (div_sh >= {1'b0, den});

  // Square root step.
  logic [D1S_W+2:0] sq_sh, sq_trial;
  logic             sq_ge;
  assign sq_sh    = {srem[D1S_W:0], rad[RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  // Scan pipeline: read, differences, squares, compare.
  logic             v1, v2, v3;
  logic [ADDR_W-1:0] idx1, idx2, idx3;
  logic [DIFF_W-1:0] dx2, dy2;
  logic             ok2, ok3;
  logic [DS_W-1:0]   ds3;
  logic [DS_W-1:0]   best;
  logic [ADDR_W-1:0] pos;
  logic signed [YV_W-1:0] yv;
  logic signed [D1S_W+1:0] dx_s;
  logic signed [YV_W-1:0]  dy_s;
  logic [D1S_W+1:0]  dx_a;
  logic [YV_W-1:0]   dy_a;
  logic              issue_more;

  assign yv   = y_neg ? -$signed({2'b00, ya}) : $signed({2'b00, ya});
  assign dx_s = $signed({2'b00, xq}) - $signed({8'd0, rd_data[19:10], {FRAC_BITS{1'b0}}});
  assign dy_s = yv - $signed({(YV_W-10-FRAC_BITS)'(0), rd_data[9:0], {FRAC_BITS{1'b0}}});
  assign dx_a = dx_s[D1S_W+1] ? (D1S_W+2)'(0) - dx_s : dx_s;
  assign dy_a = dy_s[YV_W-1] ? YV_W'(0) - dy_s : dy_s;
  assign issue_more = (issue_cnt < scan_cnt);

  // Segment walk.
  logic [2:0]  seg_i;
  logic [17:0] cb, cb_next, seg_len;
  logic [13:0] dq;
  logic        found;
  logic [2:0]  seg_r;
  logic [13:0] off_r;
  logic [17:0] off_def;

  assign dq = {pos, 4'd0};
  always_comb begin
    case (seg_i)
      3'd0, 3'd4: seg_len = {4'd0, track_length, 4'd0};
      3'd2, 3'd6: seg_len = {4'd0, track_width, 4'd0};
      default:    seg_len = {4'd0, quarter_arc_q4};
    endcase
  end
  assign cb_next = cb + seg_len;
  assign off_def = {4'd0, dq} - cb;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && command.cmd == CMD_FRAME && chk_status == ST_OK)
                state_next = S_MUL;
      S_MUL:  state_next = (h == 11'd0) ? S_SCAN : S_NUM;
      S_NUM:  state_next = S_DIV;
      S_DIV:  if (step == 6'(MAG_W - 1)) state_next = S_YFIX;
      S_YFIX: state_next = S_SQ;
      S_SQ:   state_next = (ya >= MAG_W'(d1s)) ? S_SCAN : S_RAD;
      S_RAD:  state_next = S_SQRT;
      S_SQRT: if (step == 6'(D1S_W - 1)) state_next = S_SCAN;
      S_SCAN: if (!issue_more && !v1 && !v2 && !v3) state_next = S_SEG;
      S_SEG:  if (seg_i == 3'd7) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      issue_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (state != S_SCAN) begin
        v1 <= 1'b0;
        v2 <= 1'b0;
        v3 <= 1'b0;
        issue_cnt <= '0;
      end else begin
        v1 <= issue_more;
        v2 <= v1;
        v3 <= v2;
        if (issue_more) issue_cnt <= issue_cnt + 1'b1;
      end
      if (accept && command.cmd == CMD_FRAME && chk_status != ST_OK) done <= 1'b1;
      if (state == S_SEG && seg_i == 3'd7) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        d1    <= command.dist1;
        d2    <= command.dist2;
        etag  <= command.expected_tag;
        h     <= {1'b0, track_width} + {1'b0, corner_radius, 1'b0};
        den   <= {1'b0, track_width, 1'b0} + {1'b0, corner_radius, 2'b0};
        scan_cnt <= (track_points > CNT_W'(TRACK_DEPTH)) ? CNT_W'(TRACK_DEPTH) : track_points;
        best  <= BEST_INIT;
        pos   <= '0;
        ya    <= '0;
        y_neg <= 1'b0;
        if (accept && command.cmd == CMD_FRAME && chk_status != ST_OK) begin
          result.status         <= chk_status;
          result.tag_out        <= command.expected_tag;
          result.segment        <= 3'd0;
          result.offset_q4      <= 14'd0;
          result.track_distance <= 10'd0;
        end
      end
      S_MUL: begin
        d1sq <= d1 * d1;
        d2sq <= d2 * d2;
        hsq  <= h * h;
        xq   <= d1s;
      end
      S_NUM: begin : num_blk
        logic signed [33:0] num;
        num   = $signed({2'b00, d1sq}) - $signed({2'b00, d2sq}) + $signed({12'd0, hsq});
        y_neg <= num[33];
        dvd   <= {(num[33] ? 33'(34'd0 - num) : num[32:0]), {FRAC_BITS{1'b0}}};
        drem  <= '0;
        step  <= '0;
      end
      S_DIV: begin
        drem <= div_ge ? 12'(div_sh - {1'b0, den}) : div_sh[11:0];
        dvd  <= {dvd[MAG_W-2:0], div_ge};
        step <= step + 1'b1;
      end
      S_YFIX: ya <= (y_neg && drem != 12'd0) ? dvd + 1'b1 : dvd;
      S_SQ: begin
        xq  <= '0;
        p_d <= d1s * d1s;
        p_y <= ya[D1S_W-1:0] * ya[D1S_W-1:0];
      end
      S_RAD: begin
        rad  <= p_d - p_y;
        root <= '0;
        srem <= '0;
        step <= '0;
      end
      S_SQRT: begin
        srem <= sq_ge ? sq_sh - sq_trial : sq_sh;
        root <= {root[D1S_W-2:0], sq_ge};
        rad  <= {rad[RAD_W-3:0], 2'b00};
        step <= step + 1'b1;
        if (step == 6'(D1S_W - 1)) xq <= {root[D1S_W-2:0], sq_ge};
      end
      S_SCAN: begin
        idx1 <= issue_cnt[ADDR_W-1:0];
        idx2 <= idx1;
        dx2  <= dx_a[DIFF_W-1:0];
        dy2  <= dy_a[DIFF_W-1:0];
        ok2  <= (dx_a < (D1S_W+2)'(NEAR_SPAN)) && (dy_a < YV_W'(NEAR_SPAN));
        idx3 <= idx2;
        ok3  <= ok2;
        ds3  <= DS_W'(dx2 * dx2) + DS_W'(dy2 * dy2);
        if (v3 && ok3 && ds3 < best) begin
          best <= ds3;
          pos  <= idx3;
        end
        seg_i <= 3'd0;
        cb    <= '0;
        found <= 1'b0;
      end
      S_SEG: begin
        seg_i <= seg_i + 1'b1;
        cb    <= cb_next;
        if (!found && {4'd0, dq} >= cb && {4'd0, dq} < cb_next) begin
          found <= 1'b1;
          seg_r <= seg_i;
          off_r <= 14'({4'd0, dq} - cb);
        end
        if (seg_i == 3'd7) begin
          result.status         <= ST_OK;
          result.tag_out        <= etag;
          result.track_distance <= pos;
          if (found) begin
            result.segment   <= seg_r;
            result.offset_q4 <= off_r;
          end else if ({4'd0, dq} >= cb && {4'd0, dq} < cb_next) begin
            result.segment   <= 3'd7;
            result.offset_q4 <= off_def[13:0];
          end else begin
            result.segment   <= 3'd7;
            result.offset_q4 <= ({4'd0, dq} < cb || off_def > 18'd16383) ?
                                14'd16383 : off_def[13:0];
          end
        end
      end
      default: ;
    endcase
  end

  // A load beat never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command.cmd == CMD_LOAD) |=> !done)
    else $error("result after a load beat");

  // Error results carry zero location fields.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
      (result.segment == 3'd0 && result.offset_q4 == 14'd0 && result.track_distance == 10'd0))
    else $error("error result with location fields set");

  // The scan pipeline is empty before the segment walk.
  a_scan_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEG) |-> (!v1 && !v2 && !v3))
    else $error("segment walk started with scan beats in flight");

  // While busy, no new frame can start a second result.
  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && state != S_SEG) |=> !done)
    else $error("result during frame processing");

endmodule
`default_nettype wire

// ----- tb/tag_track_locator_unit_tb.sv -----
// Testbench for the tag track locator: directed table, then random loads and frames.
`default_nettype none
module tag_track_locator_unit_tb;
  import ttl_pkg::*;

  localparam int NUM_RANDOM = 400;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t command = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_LENGTH;
  logic [13:0] cfg_data = '0;

  tag_track_locator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's configuration and point memory.
  logic [9:0]  len_q, wid_q;
  logic [8:0]  rad_q;
  logic [13:0] arc_q;
  logic [10:0] npts_q;
  logic [9:0]  mem_x [TRACK_DEPTH];
  logic [9:0]  mem_y [TRACK_DEPTH];

  result_t located_q[$];
  int errors = 0;
  int filled = 0;          // entries below this index have been written
  bit quiet = 1'b0;        // no gaps on the sender side during a stretch
  longint cycles = 0;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Works out where a frame puts the tag, updating the point mirror on loads.
  function automatic bit locate_tag(cmd_t c, output result_t r);
    longint unsigned h, d1, d2, d1s, m, den, best, cnt, pos, dq, off, dx, dy, ds;
    longint num, yq, xq;
    longint unsigned bnd [9];
    logic [2:0] seg;
    bit found;
    r = '0;
    if (c.cmd == CMD_LOAD) begin
      mem_x[c.point_index] = c.point_x;
      mem_y[c.point_index] = c.point_y;
      return 1'b0;
    end
    r.tag_out = c.expected_tag;
    if (c.header_word != HEADER_OK) r.status = ST_BAD_HDR;
    else if (c.frame_type != TYPE_OK) r.status = ST_BAD_TYPE;
    else if (c.frame_tag != {7'd0, c.expected_tag}) r.status = ST_BAD_TAG;
    else if (c.dist0 == 0 || c.dist1 == 0 || c.dist2 == 0) r.status = ST_ZERO;
    else r.status = ST_OK;
    if (r.status != ST_OK) return 1'b1;
    h = wid_q + 2 * rad_q;
    d1 = c.dist1;
    d2 = c.dist2;
    d1s = d1 << FRAC_BITS;
    if (h == 0) begin
      yq = 0;
      xq = d1s;
    end else begin
      num = longint'(d1 * d1) - longint'(d2 * d2) + longint'(h * h);
      den = 2 * h;
      m = mag(num) << FRAC_BITS;
      yq = num < 0 ? -longint'((m + den - 1) / den) : longint'(m / den);
      if (mag(yq) >= d1s) xq = 0;
      else xq = floor_sqrt(d1s * d1s - mag(yq) * mag(yq));
    end
    best = 64'd1000 << (2 * FRAC_BITS);
    cnt = npts_q < TRACK_DEPTH ? npts_q : TRACK_DEPTH;
    pos = 0;
    for (longint unsigned i = 0; i < cnt; i++) begin
      dx = mag(xq - (longint'(mem_x[i]) << FRAC_BITS));
      dy = mag(yq - (longint'(mem_y[i]) << FRAC_BITS));
      if (dx < (32 << FRAC_BITS) && dy < (32 << FRAC_BITS)) begin
        ds = dx * dx + dy * dy;
        if (ds < best) begin
          best = ds;
          pos = i;
        end
      end
    end
    bnd[0] = 0;
    bnd[1] = 16 * len_q;
    bnd[2] = bnd[1] + arc_q;
    bnd[3] = bnd[2] + 16 * wid_q;
    bnd[4] = bnd[3] + arc_q;
    bnd[5] = bnd[4] + 16 * len_q;
    bnd[6] = bnd[5] + arc_q;
    bnd[7] = bnd[6] + 16 * wid_q;
    bnd[8] = bnd[7] + arc_q;
    dq = pos << 4;
    // Past the last boundary the position saturates into the final segment.
    seg = 3'd7;
    off = dq - bnd[7];
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && dq >= bnd[i] && dq < bnd[i+1]) begin
        seg = i[2:0];
        off = dq - bnd[i];
        found = 1'b1;
      end
    end
    if (off > 16383) off = 16383;
    r.segment = seg;
    r.offset_q4 = off[13:0];
    r.track_distance = pos[9:0];
    return 1'b1;
  endfunction

  // Results are sampled at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    result_t want;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (located_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors++;
      end else begin
        want = located_q.pop_front();
        if (result.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, result.status);
        if (result.tag_out !== want.tag_out)
          $display("%0t: tag_out expected %0d actual %0d", $time, want.tag_out, result.tag_out);
        if (result.segment !== want.segment)
          $display("%0t: segment expected %0d actual %0d", $time, want.segment, result.segment);
        if (result.offset_q4 !== want.offset_q4)
          $display("%0t: offset_q4 expected %0d actual %0d", $time, want.offset_q4,
                   result.offset_q4);
        if (result.track_distance !== want.track_distance)
          $display("%0t: track_distance expected %0d actual %0d", $time,
                   want.track_distance, result.track_distance);
        if (result !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Presents one beat, with a random gap first, and holds it until accepted.
  // Start stays high afterwards so the next beat can follow with no gap.
  task automatic send_beat(cmd_t c, bit typed, result_t typed_res);
    result_t r;
    bit has;
    while (!quiet && $urandom_range(99) < 14) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    has = locate_tag(c, r);
    if (typed) r = typed_res;
    if (has) located_q = {located_q, r};
  endtask

  // Lets the block go idle before a register write.
  task automatic drain_block();
    start <= 1'b0;
    while (located_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [13:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LENGTH: len_q = val[9:0];
      REG_WIDTH:  wid_q = val[9:0];
      REG_RADIUS: rad_q = val[8:0];
      REG_ARC:    arc_q = val;
      REG_POINTS: npts_q = val[10:0];
      default: ;
    endcase
  endtask

  function automatic cmd_t load_beat(int idx, int x, int y);
    cmd_t c;
    c = '0;
    c.cmd = CMD_LOAD;
    c.point_index = 10'(idx);
    c.point_x = 10'(x);
    c.point_y = 10'(y);
    c.header_word = 16'($urandom());
    c.dist1 = 16'($urandom());
    return c;
  endfunction

  function automatic cmd_t frame_beat(int d0, int d1, int d2, bit tag);
    cmd_t c;
    c = '0;
    c.cmd = CMD_FRAME;
    c.point_index = 10'($urandom());
    c.point_x = 10'($urandom());
    c.point_y = 10'($urandom());
    c.header_word = HEADER_OK;
    c.frame_type = TYPE_OK;
    c.frame_tag = {7'd0, tag};
    c.expected_tag = tag;
    c.dist0 = 16'(d0);
    c.dist1 = 16'(d1);
    c.dist2 = 16'(d2);
    return c;
  endfunction

  // A row of the directed table; typed rows carry their result written out.
  typedef struct {
    cmd_t    beat;
    bit      typed;
    result_t res;
  } row_t;

  // Writes every entry of the searched range not written yet, x following the index.
  task automatic fill_points(int count);
    for (int i = filled; i < count; i++)
      send_beat(load_beat(i, i % 1024, $urandom_range(0, 1023)), 1'b0, '0);
    if (count > filled) filled = count;
  endtask

  initial begin
    row_t dir_rows[$];
    row_t rw;
    cmd_t c;
    int x, y;
    len_q = 10'd122;
    wid_q = 10'd80;
    rad_q = 9'd85;
    arc_q = 14'd2136;
    npts_q = 11'd938;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Small search set so the directed frames finish quickly; every point written.
    write_reg(REG_POINTS, 14'd16);
    for (int i = 0; i < 16; i++)
      send_beat(load_beat(i, i * 13, 250 - i * 3), 1'b0, '0);
    send_beat(load_beat(1023, 1023, 1023), 1'b0, '0);
    send_beat(load_beat(15, 0, 0), 1'b0, '0);
    filled = 16;

    // Error rows: checked in the order header, type, tag, distances.
    c = frame_beat(1, 1, 1, 1'b1); c.header_word = 16'hD66C;
    rw = '{c, 1'b1, '{ST_BAD_HDR, 1'b1, 3'd0, 14'd0, 10'd0}}; dir_rows = {dir_rows, rw};
    c = frame_beat(0, 0, 0, 1'b0); c.header_word = 16'hFFFF; c.frame_type = 8'hFF;
    rw = '{c, 1'b1, '{ST_BAD_HDR, 1'b0, 3'd0, 14'd0, 10'd0}}; dir_rows = {dir_rows, rw};
    c = frame_beat(1, 1, 1, 1'b0); c.frame_type = 8'hFF;
    rw = '{c, 1'b1, '{ST_BAD_TYPE, 1'b0, 3'd0, 14'd0, 10'd0}}; dir_rows = {dir_rows, rw};
    c = frame_beat(1, 1, 1, 1'b1); c.frame_tag = 8'hFF;
    rw = '{c, 1'b1, '{ST_BAD_TAG, 1'b1, 3'd0, 14'd0, 10'd0}}; dir_rows = {dir_rows, rw};
    c = frame_beat(1, 1, 1, 1'b0); c.frame_tag = 8'h80;
    rw = '{c, 1'b1, '{ST_BAD_TAG, 1'b0, 3'd0, 14'd0, 10'd0}}; dir_rows = {dir_rows, rw};
    c = frame_beat(0, 5, 5, 1'b1);
    rw = '{c, 1'b1, '{ST_ZERO, 1'b1, 3'd0, 14'd0, 10'd0}}; dir_rows = {dir_rows, rw};
    c = frame_beat(5, 0, 5, 1'b0);
    rw = '{c, 1'b1, '{ST_ZERO, 1'b0, 3'd0, 14'd0, 10'd0}}; dir_rows = {dir_rows, rw};
    c = frame_beat(5, 5, 0, 1'b1);
    rw = '{c, 1'b1, '{ST_ZERO, 1'b1, 3'd0, 14'd0, 10'd0}}; dir_rows = {dir_rows, rw};
    // Good frames: extremes of the ranges, no intersection, equal ranges, near points.
    c = frame_beat(65535, 65535, 65535, 1'b1); rw = '{c, 1'b0, '0}; dir_rows = {dir_rows, rw};
    c = frame_beat(1, 1, 65535, 1'b0);         rw = '{c, 1'b0, '0}; dir_rows = {dir_rows, rw};
    c = frame_beat(1, 65535, 1, 1'b1);         rw = '{c, 1'b0, '0}; dir_rows = {dir_rows, rw};
    c = frame_beat(9, 200, 130, 1'b0);         rw = '{c, 1'b0, '0}; dir_rows = {dir_rows, rw};
    c = frame_beat(9, 130, 200, 1'b1);         rw = '{c, 1'b0, '0}; dir_rows = {dir_rows, rw};
    c = frame_beat(7, 250, 1, 1'b0);           rw = '{c, 1'b0, '0}; dir_rows = {dir_rows, rw};
    c = frame_beat(7, 21845, 43690, 1'b1);     rw = '{c, 1'b0, '0}; dir_rows = {dir_rows, rw};
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].res);

    // Zero track height: y is zero and x is the first range.
    drain_block();
    write_reg(REG_WIDTH, 14'd0);
    write_reg(REG_RADIUS, 14'd0);
    send_beat(frame_beat(3, 20, 77, 1'b1), 1'b0, '0);
    send_beat(frame_beat(3, 1, 1, 1'b0), 1'b0, '0);

    // Random phases over several settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      drain_block();
      case (ph)
        0: begin
          write_reg(REG_LENGTH, 14'd0); write_reg(REG_WIDTH, 14'd0);
          write_reg(REG_RADIUS, 14'd1); write_reg(REG_ARC, 14'd0);
          write_reg(REG_POINTS, 14'd64);
        end
        1: begin
          write_reg(REG_LENGTH, 14'd1023); write_reg(REG_WIDTH, 14'd1023);
          write_reg(REG_RADIUS, 14'd511); write_reg(REG_ARC, 14'd16383);
          write_reg(REG_POINTS, 14'd48);
        end
        2: begin
          write_reg(REG_LENGTH, 14'd2); write_reg(REG_WIDTH, 14'd1);
          write_reg(REG_RADIUS, 14'd3); write_reg(REG_ARC, 14'd20);
          write_reg(REG_POINTS, 14'd0);
        end
        3: begin
          // Reset geometry with a longer search.
          write_reg(REG_LENGTH, 14'd122); write_reg(REG_WIDTH, 14'd80);
          write_reg(REG_RADIUS, 14'd85); write_reg(REG_ARC, 14'd2136);
          write_reg(REG_POINTS, 14'd128);
        end
        4: begin
          // A shorter search over entries written before.
          write_reg(REG_POINTS, 14'd100);
        end
        default: begin
          write_reg(REG_LENGTH, 14'($urandom_range(0, 1023)));
          write_reg(REG_WIDTH, 14'($urandom_range(0, 1023)));
          write_reg(REG_RADIUS, 14'($urandom_range(1, 511)));
          write_reg(REG_ARC, 14'($urandom_range(0, 16383)));
          write_reg(REG_POINTS, 14'd32);
        end
      endcase
      fill_points(int'(npts_q));
      quiet = (ph == 2);
      for (int n = 0; n < NUM_RANDOM / 6; n++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            x = $urandom_range(0, 1023);
            send_beat(load_beat($urandom_range(0, 1023), x, $urandom_range(0, 1023)),
                      1'b0, '0);
          end
          2: begin
            c = '0;
            c.cmd = CMD_FRAME;
            c.point_index = 10'($urandom());
            c.header_word = $urandom_range(0, 1) ? HEADER_OK : 16'($urandom());
            c.frame_type = 8'($urandom_range(0, 3));
            c.frame_tag = 8'($urandom_range(0, 2));
            c.expected_tag = 1'($urandom_range(0, 1));
            c.dist0 = 16'($urandom());
            c.dist1 = 16'($urandom());
            c.dist2 = 16'($urandom());
            send_beat(c, 1'b0, '0);
          end
          default: begin
            // Aim at a stored point so the search often finds one in range.
            y = $urandom_range(0, 1023);
            x = $urandom_range(1, 1400);
            send_beat(frame_beat($urandom_range(1, 65535),
                                 $urandom_range(0, 3) == 0 ? $urandom_range(1, 65535) : x,
                                 $urandom_range(0, 3) == 0 ? $urandom_range(1, 65535)
                                   : $urandom_range(1, 2000),
                                 1'($urandom_range(0, 1))), 1'b0, '0);
          end
        endcase
      end
      quiet = 1'b0;
    end

    drain_block();
    repeat (20) @(posedge clk);
    if (errors == 0 && located_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- tag_track_locator_unit.f -----
rtl/ttl_pkg.sv
rtl/tag_track_locator_unit.sv
tb/tag_track_locator_unit_tb.sv
